// ----- rtl/vts_pkg.sv -----
// vts_pkg: shared types, codes and reset values for the valve transit supervisor
// no dependencies; referenced by the request interface and imported by every module of the block

package vts_pkg;

	// field widths
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned DEBOUNCE_W = 16;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 1;

	// request types
	localparam logic [1:0] REQ_UPDATE = 2'd0;
	localparam logic [1:0] REQ_OPEN   = 2'd1;
	localparam logic [1:0] REQ_CLOSE  = 2'd2;

	// servo commands
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_FULL = 2'd1;
	localparam logic [1:0] CMD_SHUT = 2'd2;

	// valve state codes as reported on the result channel
	localparam logic [2:0] VS_UNKNOWN = 3'd0;
	localparam logic [2:0] VS_OPENING = 3'd1;
	localparam logic [2:0] VS_OPEN    = 3'd2;
	localparam logic [2:0] VS_CLOSING = 3'd3;
	localparam logic [2:0] VS_CLOSED  = 3'd4;
	localparam logic [2:0] VS_FAULT   = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd1;

	// configuration reset values
	localparam logic [TIME_W-1:0]     TIMEOUT_RESET  = 32'd1000;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd30;

	// internal valve mode, one-hot
	typedef enum logic [5:0] {
		MODE_UNKNOWN = 6'b000001,
		MODE_OPENING = 6'b000010,
		MODE_OPEN    = 6'b000100,
		MODE_CLOSING = 6'b001000,
		MODE_CLOSED  = 6'b010000,
		MODE_FAULT   = 6'b100000
	} mode_t;

	// supervisor state carried between the step logic and the top level
	typedef struct packed {
		mode_t             mode;
		logic [TIME_W-1:0] start_ms;
		logic [TIME_W-1:0] last_chg_ms;
		logic              open_lvl;
		logic              close_lvl;
	} vts_state_t;

	// one-hot mode to reported state code
	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		case (m)
			MODE_UNKNOWN: c = VS_UNKNOWN;
			MODE_OPENING: c = VS_OPENING;
			MODE_OPEN:    c = VS_OPEN;
			MODE_CLOSING: c = VS_CLOSING;
			MODE_CLOSED:  c = VS_CLOSED;
			MODE_FAULT:   c = VS_FAULT;
			default:      c = VS_UNKNOWN;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/vts_ifs.sv -----
// vts_ifs: valid/ready channel interfaces for requests and results
// depends on vts_pkg for field widths

interface vts_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic [vts_pkg::TIME_W-1:0] now_ms;
	logic                      raw_open_limit;
	logic                      raw_close_limit;

	modport source (output valid, req_type, now_ms, raw_open_limit, raw_close_limit,
		input ready);
	modport sink (input valid, req_type, now_ms, raw_open_limit, raw_close_limit,
		output ready);
endinterface

interface vts_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] valve_state;
	logic [1:0] servo_command;
	logic       open_limit_seen;
	logic       close_limit_seen;

	modport source (output valid, valve_state, servo_command, open_limit_seen,
		close_limit_seen, input ready);
	modport sink (input valid, valve_state, servo_command, open_limit_seen,
		close_limit_seen, output ready);
endinterface

// ----- rtl/vts_step.sv -----
// vts_step: next-state logic for one request (commands, debounce, transit end and timeout)
// depends on vts_pkg

module vts_step (
	input  vts_pkg::vts_state_t              cur,
	input  logic [1:0]                       req_type,
	input  logic [vts_pkg::TIME_W-1:0]       now_ms,
	input  logic                             raw_open,
	input  logic                             raw_close,
	input  logic [vts_pkg::TIME_W-1:0]       timeout_ms,
	input  logic [vts_pkg::DEBOUNCE_W-1:0]   debounce_ms,
	output vts_pkg::vts_state_t              nxt,
	output logic [1:0]                       servo_command
);
	import vts_pkg::*;

	logic [TIME_W-1:0] since_chg;
	logic [TIME_W-1:0] since_start;
	logic              lvl_diff;
	logic              deb_ok;
	logic              expired;

	// elapsed times, modulo 2^32
	assign since_chg   = now_ms - cur.last_chg_ms;
	assign since_start = now_ms - cur.start_ms;
	assign lvl_diff    = (raw_open != cur.open_lvl) || (raw_close != cur.close_lvl);
	assign deb_ok      = since_chg >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms};
	assign expired     = since_start >= timeout_ms;

	// request decode and state update
	always_comb begin
		nxt           = cur;
		servo_command = CMD_NONE;
		case (req_type)
			REQ_OPEN: begin
				if (cur.mode != MODE_OPEN && cur.mode != MODE_OPENING) begin
					nxt.start_ms  = now_ms;
					nxt.mode      = MODE_OPENING;
					servo_command = CMD_FULL;
				end
			end
			REQ_CLOSE: begin
				if (cur.mode != MODE_CLOSED && cur.mode != MODE_CLOSING) begin
					nxt.start_ms  = now_ms;
					nxt.mode      = MODE_CLOSING;
					servo_command = CMD_SHUT;
				end
			end
			REQ_UPDATE: begin
				// both switches debounced together
				if (lvl_diff && deb_ok) begin
					nxt.open_lvl    = raw_open;
					nxt.close_lvl   = raw_close;
					nxt.last_chg_ms = now_ms;
				end
				// transit ends on the debounced switch, else may time out
				if (cur.mode == MODE_OPENING) begin
					if (nxt.open_lvl)
						nxt.mode = MODE_OPEN;
					else if (expired)
						nxt.mode = MODE_FAULT;
				end else if (cur.mode == MODE_CLOSING) begin
					if (nxt.close_lvl)
						nxt.mode = MODE_CLOSED;
					else if (expired)
						nxt.mode = MODE_FAULT;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ----- rtl/valve_transit_supervisor_core.sv -----
// valve_transit_supervisor_core: top level with input register, state and result register
// depends on vts_pkg, vts_ifs and vts_step

// Takes one request transaction per clock while req.ready is high and returns exactly
// one result transaction for each. A request is captured in an input register; once the
// result register is free or being taken, one pass of compare/subtract logic updates the
// valve state and loads the result register, so a sustained rate of one transaction per
// cycle with the result side ready is set by that single state-update step. A waiting
// result blocks the next request only while the input register is full. Configuration
// (index 0 transit timeout, index 1 debounce time) is written through cfg_we/cfg_index/
// cfg_wdata; the user must write it only while no transaction is in flight, as the block
// does not enforce this. Timeout resets to 1000 ms, debounce to 30 ms.

module valve_transit_supervisor_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	vts_req_if.sink                           req,
	vts_res_if.source                         res
);
	import vts_pkg::*;

	// configuration registers
	logic [TIME_W-1:0]     timeout_q;
	logic [DEBOUNCE_W-1:0] debounce_q;

	// supervisor state
	vts_state_t state_q;
	vts_state_t nxt;

	// input stage
	logic              valid_s1;
	logic [1:0]        req_type_s1;
	logic [TIME_W-1:0] now_ms_s1;
	logic              raw_open_s1;
	logic              raw_close_s1;

	// result stage
	logic       valid_s2;
	logic [2:0] state_s2;
	logic [1:0] cmd_s2;
	logic       open_s2;
	logic       close_s2;

	logic [1:0] cmd;
	logic       adv;

	// flow control
	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !valid_s1 || adv;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RESET;
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT:  timeout_q  <= cfg_wdata;
				CFG_DEBOUNCE: debounce_q <= cfg_wdata[DEBOUNCE_W-1:0];
				default:      timeout_q  <= timeout_q;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1  <= req.req_type;
			now_ms_s1    <= req.now_ms;
			raw_open_s1  <= req.raw_open_limit;
			raw_close_s1 <= req.raw_close_limit;
		end
	end

	vts_step u_step (
		.cur           (state_q),
		.req_type      (req_type_s1),
		.now_ms        (now_ms_s1),
		.raw_open      (raw_open_s1),
		.raw_close     (raw_close_s1),
		.timeout_ms    (timeout_q),
		.debounce_ms   (debounce_q),
		.nxt           (nxt),
		.servo_command (cmd)
	);

	// state update as each transaction passes to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= MODE_UNKNOWN;
			state_q.start_ms    <= '0;
			state_q.last_chg_ms <= '0;
			state_q.open_lvl    <= 1'b0;
			state_q.close_lvl   <= 1'b0;
		end else if (adv) begin
			state_q <= nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (res.ready)
			valid_s2 <= 1'b0;
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			state_s2 <= mode_code(nxt.mode);
			cmd_s2   <= cmd;
			open_s2  <= nxt.open_lvl;
			close_s2 <= nxt.close_lvl;
		end
	end

	assign res.valid            = valid_s2;
	assign res.valve_state      = state_s2;
	assign res.servo_command    = cmd_s2;
	assign res.open_limit_seen  = open_s2;
	assign res.close_limit_seen = close_s2;

	// a new servo command always comes with the matching transit mode
	a_cmd_full: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.servo_command == CMD_FULL |-> res.valve_state == VS_OPENING)
		else $error("open command without opening state");

	a_cmd_shut: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.servo_command == CMD_SHUT |-> res.valve_state == VS_CLOSING)
		else $error("close command without closing state");

	// state moves only when a transaction advances
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("state changed without a transaction");

	// fault is entered only from a transit
	a_fault_src: assert property (@(posedge clk) disable iff (!arst_n)
		adv && nxt.mode == MODE_FAULT && state_q.mode != MODE_FAULT
		|-> state_q.mode == MODE_OPENING || state_q.mode == MODE_CLOSING)
		else $error("fault entered outside a transit");

endmodule

// ----- tb/sv/valve_transit_supervisor_core_test.sv -----
`timescale 1ns / 100ps
// valve_transit_supervisor_core_test: self-checking testbench for the valve transit supervisor
// depends on vts_pkg, vts_ifs and valve_transit_supervisor_core; drives requests and checks results

module valve_transit_supervisor_core_test;
	import vts_pkg::*;

	localparam int          CLK_PERIOD        = 10;
	localparam int          RESET_CYCLES      = 7;
	localparam int          DRAIN_CYCLES      = 6;
	localparam int          LONG_STALL_CYCLES = 300;
	localparam longint      RUN_LIMIT_NS      = 64'd5_000_000;
	localparam logic [1:0]  REQ_UNUSED        = 2'd3;

	// one request transaction
	typedef struct packed {
		logic [1:0]        req_type;
		logic [TIME_W-1:0] now_ms;
		logic              raw_open_limit;
		logic              raw_close_limit;
	} req_item_t;

	// one result transaction
	typedef struct packed {
		logic [2:0] valve_state;
		logic [1:0] servo_command;
		logic       open_limit_seen;
		logic       close_limit_seen;
	} valve_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	vts_req_if req_ch ();
	vts_res_if res_ch ();

	valve_transit_supervisor_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	// supervisor shadow state and configuration
	logic [2:0]            valve_code;
	logic [TIME_W-1:0]     transit_start;
	logic [TIME_W-1:0]     last_switch_change;
	logic                  open_seen;
	logic                  close_seen;
	logic [TIME_W-1:0]     timeout_limit;
	logic [DEBOUNCE_W-1:0] debounce_limit;

	valve_result_t         expected_results[$];
	int                    error_count = 0;
	int                    items_sent = 0;
	int                    long_stall_asked = 0;
	bit                    pace_bursts = 1'b1;
	int                    burst_left = 0;
	logic [TIME_W-1:0]     clock_ms = '0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#(RUN_LIMIT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void reset_shadow();
		valve_code         = VS_UNKNOWN;
		transit_start      = '0;
		last_switch_change = '0;
		open_seen          = 1'b0;
		close_seen         = 1'b0;
		timeout_limit      = TIMEOUT_RESET;
		debounce_limit     = DEBOUNCE_RESET;
	endfunction

	// next valve state and result for one request
	function automatic valve_result_t predict_valve(input req_item_t item);
		valve_result_t     r;
		logic [TIME_W-1:0] since_change;
		logic [TIME_W-1:0] in_transit;
		r.servo_command = CMD_NONE;
		case (item.req_type)
			REQ_OPEN: begin
				if (valve_code != VS_OPEN && valve_code != VS_OPENING) begin
					transit_start   = item.now_ms;
					valve_code      = VS_OPENING;
					r.servo_command = CMD_FULL;
				end
			end
			REQ_CLOSE: begin
				if (valve_code != VS_CLOSED && valve_code != VS_CLOSING) begin
					transit_start   = item.now_ms;
					valve_code      = VS_CLOSING;
					r.servo_command = CMD_SHUT;
				end
			end
			REQ_UPDATE: begin
				// both switches debounced together
				since_change = item.now_ms - last_switch_change;
				if ((item.raw_open_limit != open_seen || item.raw_close_limit != close_seen)
					&& since_change >= {16'd0, debounce_limit}) begin
					open_seen          = item.raw_open_limit;
					close_seen         = item.raw_close_limit;
					last_switch_change = item.now_ms;
				end
				// end of transit or timeout
				in_transit = item.now_ms - transit_start;
				if (valve_code == VS_OPENING) begin
					if (open_seen)
						valve_code = VS_OPEN;
					else if (in_transit >= timeout_limit)
						valve_code = VS_FAULT;
				end else if (valve_code == VS_CLOSING) begin
					if (close_seen)
						valve_code = VS_CLOSED;
					else if (in_transit >= timeout_limit)
						valve_code = VS_FAULT;
				end
			end
			default: ;
		endcase
		r.valve_state      = valve_code;
		r.open_limit_seen  = open_seen;
		r.close_limit_seen = close_seen;
		return r;
	endfunction

	// expectation for every accepted request transaction
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			expected_results.push_back(predict_valve('{req_ch.req_type, req_ch.now_ms,
				req_ch.raw_open_limit, req_ch.raw_close_limit}));
	end

	task automatic compare_field(input string field, input logic [7:0] expected_v,
		input logic [7:0] actual_v);
		if (actual_v !== expected_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field,
				expected_v, actual_v);
			error_count++;
		end
	endtask

	// check each result transaction against the oldest expectation
	always @(posedge clk) begin
		valve_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual state %0d command %0d",
					$time, res_ch.valve_state, res_ch.servo_command);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("valve_state", 8'(want.valve_state), 8'(res_ch.valve_state));
				compare_field("servo_command", 8'(want.servo_command),
					8'(res_ch.servo_command));
				compare_field("open_limit_seen", 8'(want.open_limit_seen),
					8'(res_ch.open_limit_seen));
				compare_field("close_limit_seen", 8'(want.close_limit_seen),
					8'(res_ch.close_limit_seen));
			end
		end
	end

	// result side: stall patterns that change now and then, plus long hold-offs on demand
	initial begin : result_receiver
		int hold_left;
		int mode_left;
		int stall_mode;
		int stalls_served;
		res_ch.ready  = 1'b0;
		hold_left     = 0;
		mode_left     = 0;
		stall_mode    = 0;
		stalls_served = 0;
		forever begin
			@(posedge clk);
			if (long_stall_asked != stalls_served) begin
				stalls_served = long_stall_asked;
				hold_left     = LONG_STALL_CYCLES;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(16, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0:       res_ch.ready <= 1'b1;
					1:       res_ch.ready <= ($urandom_range(0, 1) == 0);
					2:       res_ch.ready <= ($urandom_range(0, 9) != 0);
					default: res_ch.ready <= (mode_left % 4 != 0);
				endcase
			end
		end
	end

	// offer one request and hold it until the transaction completes
	task automatic send_request(input req_item_t item);
		req_ch.valid           <= 1'b1;
		req_ch.req_type        <= item.req_type;
		req_ch.now_ms          <= item.now_ms;
		req_ch.raw_open_limit  <= item.raw_open_limit;
		req_ch.raw_close_limit <= item.raw_close_limit;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// request side: when pacing is on, bursts of random length with random gaps
	task automatic send_paced(input req_item_t item);
		int gap;
		send_request(item);
		if (pace_bursts) begin
			burst_left--;
			if (burst_left <= 0) begin
				gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 6);
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	task automatic send_fields(input logic [1:0] req_type, input logic [TIME_W-1:0] now_ms,
		input logic raw_open, input logic raw_close);
		send_paced('{req_type, now_ms, raw_open, raw_close});
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (index == CFG_TIMEOUT)
			timeout_limit = data;
		else
			debounce_limit = data[DEBOUNCE_W-1:0];
	endtask

	task automatic write_settings(input logic [TIME_W-1:0] timeout_ms,
		input logic [DEBOUNCE_W-1:0] debounce_ms);
		logic [15:0] junk;
		junk = 16'($urandom);
		wait_results_drained();
		write_register(CFG_TIMEOUT, timeout_ms);
		// upper bits of the debounce write carry junk that must be dropped
		write_register(CFG_DEBOUNCE, {junk, debounce_ms});
	endtask

	// one open or close followed by updates from a simulated valve with bounce
	task automatic run_transit(input int n_updates, input int step_max);
		req_item_t item;
		bit        to_open;
		int        travel;
		int        elapsed;
		int        step;
		to_open              = 1'($urandom_range(0, 1));
		travel               = $urandom_range(0, 500);
		item.req_type        = to_open ? REQ_OPEN : REQ_CLOSE;
		item.now_ms          = clock_ms;
		item.raw_open_limit  = 1'($urandom_range(0, 1));
		item.raw_close_limit = 1'($urandom_range(0, 1));
		send_paced(item);
		elapsed = 0;
		for (int i = 0; i < n_updates; i++) begin
			step = $urandom_range(0, step_max);
			if ($urandom_range(0, 40) == 0) begin
				clock_ms += $urandom;
				elapsed   = travel;
			end else begin
				clock_ms += step;
				elapsed  += step;
			end
			item.req_type        = REQ_UPDATE;
			item.now_ms          = clock_ms;
			item.raw_open_limit  = to_open && elapsed >= travel;
			item.raw_close_limit = !to_open && elapsed >= travel;
			case ($urandom_range(0, 11))
				0: item.raw_open_limit  = ~item.raw_open_limit;
				1: item.raw_close_limit = ~item.raw_close_limit;
				2: item.req_type        = to_open ? REQ_OPEN : REQ_CLOSE;
				3: item.req_type        = to_open ? REQ_CLOSE : REQ_OPEN;
				default: ;
			endcase
			send_paced(item);
		end
	endtask

	task automatic send_noise_item();
		req_item_t item;
		item.req_type        = 2'($urandom_range(0, 3));
		item.now_ms          = $urandom_range(0, 1) ? $urandom : clock_ms + $urandom_range(0, 100);
		item.raw_open_limit  = 1'($urandom_range(0, 1));
		item.raw_close_limit = 1'($urandom_range(0, 1));
		send_paced(item);
	endtask

	// reset defaults, every request type and the transit outcomes
	task automatic test_directed_sequences();
		send_fields(REQ_UPDATE, 32'd0, 1'b0, 1'b0);
		send_fields(REQ_UNUSED, 32'd5, 1'b1, 1'b1);
		// debounce boundary from the reset change time
		send_fields(REQ_UPDATE, 32'd29, 1'b1, 1'b0);
		send_fields(REQ_UPDATE, 32'd30, 1'b1, 1'b0);
		// open from unknown, repeated open ignored
		send_fields(REQ_OPEN, 32'd40, 1'b0, 1'b0);
		send_fields(REQ_OPEN, 32'd41, 1'b0, 1'b0);
		send_fields(REQ_UPDATE, 32'd45, 1'b1, 1'b0);
		send_fields(REQ_OPEN, 32'd46, 1'b0, 1'b1);
		// close with timeout boundary
		send_fields(REQ_CLOSE, 32'd100, 1'b0, 1'b0);
		send_fields(REQ_CLOSE, 32'd101, 1'b0, 1'b0);
		send_fields(REQ_UPDATE, 32'd1099, 1'b1, 1'b0);
		send_fields(REQ_UPDATE, 32'd1100, 1'b1, 1'b0);
		// commands from fault
		send_fields(REQ_CLOSE, 32'd1200, 1'b0, 1'b0);
		send_fields(REQ_UPDATE, 32'd1210, 1'b0, 1'b1);
		// transit across the wrap of the tick counter
		send_fields(REQ_OPEN, 32'hFFFF_FFF0, 1'b0, 1'b0);
		send_fields(REQ_UPDATE, 32'h0000_0005, 1'b1, 1'b1);
		send_fields(REQ_UPDATE, 32'h0000_0006, 1'b0, 1'b0);
		send_fields(REQ_UNUSED, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_fields(REQ_CLOSE, 32'h0000_0010, 1'b1, 1'b1);
		send_fields(REQ_UPDATE, 32'h0000_0011, 1'b1, 1'b1);
		send_fields(REQ_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b0);
	endtask

	// zero and full-scale timeout and debounce
	task automatic test_config_extremes();
		write_settings(32'd0, 16'd0);
		send_fields(REQ_OPEN, 32'd500, 1'b0, 1'b0);
		send_fields(REQ_UPDATE, 32'd500, 1'b0, 1'b0);
		send_fields(REQ_CLOSE, 32'd600, 1'b0, 1'b0);
		send_fields(REQ_UPDATE, 32'd600, 1'b0, 1'b1);
		write_settings(32'hFFFF_FFFF, 16'hFFFF);
		send_fields(REQ_OPEN, 32'd1000, 1'b0, 1'b0);
		send_fields(REQ_UPDATE, 32'd998, 1'b0, 1'b1);
		send_fields(REQ_UPDATE, 32'd66134, 1'b1, 1'b0);
		send_fields(REQ_UPDATE, 32'd66135, 1'b1, 1'b0);
	endtask

	// mostly well-formed transits under a series of settings
	task automatic test_random_transits(input int phase_count, input int items_per_phase);
		int target;
		for (int p = 0; p < phase_count; p++) begin
			case (p)
				1:       write_settings(32'd0, 16'd0);
				2:       write_settings(32'hFFFF_FFFF, 16'hFFFF);
				default: write_settings(32'($urandom_range(60, 400)),
					16'($urandom_range(0, 40)));
			endcase
			pace_bursts = (p % 3 != 0);
			clock_ms    = $urandom;
			target      = items_sent + items_per_phase;
			while (items_sent < target) begin
				if ($urandom_range(0, 9) == 0)
					send_noise_item();
				else
					run_transit($urandom_range(1, 16), $urandom_range(1, 60));
			end
		end
	endtask

	// long receiver hold-off while requests keep coming, then a full pause
	task automatic test_result_backpressure();
		write_settings(TIMEOUT_RESET, DEBOUNCE_RESET);
		pace_bursts = 1'b0;
		long_stall_asked++;
		repeat (6) run_transit(12, 30);
		wait_results_drained();
	endtask

	// arbitrary field values, unused request type included
	task automatic test_request_noise(input int n_items);
		write_settings($urandom, 16'($urandom));
		pace_bursts = 1'b1;
		repeat (n_items) send_noise_item();
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_TIMEOUT;
		cfg_wdata              = '0;
		req_ch.valid           = 1'b0;
		req_ch.req_type        = REQ_UPDATE;
		req_ch.now_ms          = '0;
		req_ch.raw_open_limit  = 1'b0;
		req_ch.raw_close_limit = 1'b0;
		reset_shadow();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_sequences();
		test_config_extremes();
		test_random_transits(7, 180);
		test_result_backpressure();
		test_request_noise(200);
		wait_results_drained();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- valve_transit_supervisor_core.f -----
rtl/vts_pkg.sv
rtl/vts_ifs.sv
rtl/vts_step.sv
rtl/valve_transit_supervisor_core.sv
tb/sv/valve_transit_supervisor_core_test.sv
